/* src/gtms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaze trimmed-mean smoother package
// Shared word types and register addresses.
// ----------------------------------------------------------------------------
package gtms_pkg;
  localparam int CoordBits  = 16;
  localparam int SpreadBits = 23;

  localparam logic [0:0] RegBypass = 1'b0;

  typedef struct packed {
    logic                        eye;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] smooth_x;
    logic signed [CoordBits-1:0] smooth_y;
    logic [SpreadBits-1:0]       spread;
  } out_word_t;
endpackage
`default_nettype wire

/* src/gtms_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gtms_ram #(
  parameter int Width = 16,
  parameter int Depth = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/gtms_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module gtms_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] rem;
  logic [31:0] res;
  logic [5:0]  cnt;
  logic        busy;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  assign rem_sh = {rem, 2'b00};
  assign trial  = {32'd0, res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder is kept as (high part, remaining input bits) in one shifting pair.
  logic [63:0] src;
  logic [65:0] cur;

  assign cur = {rem[63:0], src[63:62]};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 64'd0;
      res <= 32'd0;
      src <= value;
    end else if (busy) begin
      src <= {src[61:0], 2'b00};
      if (cur >= trial) begin
        rem <= 64'(cur - trial);
        res <= {res[30:0], 1'b1};
      end else begin
        rem <= cur[63:0];
        res <= {res[30:0], 1'b0};
      end
    end
  end

  assign root = res;

  logic unused;
  assign unused = ^rem_sh;
endmodule
`default_nettype wire

/* src/gaze_trimmed_mean_smoother_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaze trimmed-mean smoother
// Per-eye trimmed moving average with a spread estimate.
// ----------------------------------------------------------------------------
// Each accepted word runs through the states in order; with bypass set the
// raw sum, deviation, trim and divide states are skipped. The ring
// memories are walked one entry a cycle for the raw sum and for the trimmed
// sum. The deviation maxima take two passes over the entries, and the
// spread takes one such pass. The spread root comes from the iterative
// square-root unit. One word is handled at a time and in_stall
// stays high meanwhile. The result word sits in an output register, so the
// next input is taken while it waits, and a finished word waits for that
// register to empty.
module gaze_trimmed_mean_smoother_core #(
  parameter int WINDOW = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gtms_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gtms_pkg::out_word_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import gtms_pkg::*;

  localparam int IW    = $clog2(WINDOW);
  localparam int Depth = 2 * WINDOW;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = CoordBits + $clog2(WINDOW + 1) + 1;
  localparam int DW    = SW + 1;
  localparam logic [IW-1:0] Last = IW'(WINDOW - 1);
  localparam logic [IW:0]   Tail = (IW+1)'(WINDOW + 1);
  localparam int Keep  = WINDOW - 2;
  localparam int QShift = SW - 1 + $clog2(Keep);
  localparam logic [SW-1:0] QMul =
    SW'(((64'd1 << QShift) + 64'(Keep - 1)) / 64'(Keep));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_DEV   = 4'd2;
  localparam logic [3:0] S_TRIM  = 4'd3;
  localparam logic [3:0] S_DIVX  = 4'd4;
  localparam logic [3:0] S_DIVY  = 4'd5;
  localparam logic [3:0] S_SSUM  = 4'd6;
  localparam logic [3:0] S_SDEV  = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_WRS   = 4'd10;

  logic [3:0] state;
  logic       bypass;
  logic       eye;
  logic signed [CoordBits-1:0] ox, oy;
  logic [IW-1:0] slot [2];
  logic [IW-1:0] idx;
  logic [IW:0]   step;
  logic [1:0]    sub;
  logic signed [SW-1:0] sx, sy, tx, ty;
  logic [63:0] dev_max1, dev_max2, acc;
  logic [IW-1:0] d1, d2;
  logic          pass2;

  // Shared multiplier operand and registered square.
  logic signed [DW-1:0]   mul_a;
  logic signed [2*DW-1:0] mul_w;
  logic [2*DW-1:0]        sq;

  logic [AW-1:0] raddr, waddr;
  logic          raw_we, sm_we;
  logic [CoordBits-1:0] raw_wx, raw_wy, sm_wx, sm_wy;
  logic [CoordBits-1:0] rx, ry, smx, smy;
  logic [IW-1:0] ridx;

  logic sq_start, sq_done;
  logic [31:0] root;

  assign pready = 1'b1;
  assign prdata = {31'd0, bypass};
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (psel && penable && pwrite && paddr == {RegBypass, 1'b0}) begin
      bypass <= pwdata[0];
    end
  end

  assign waddr = (eye ? AW'(WINDOW) : AW'(0)) + AW'(slot[eye]);
  assign raddr = (eye ? AW'(WINDOW) : AW'(0)) + AW'(idx);
  assign raw_we = (state == S_IDLE) && in_valid && !in_stall && !bypass;
  assign raw_wx = in_data.pos_x;
  assign raw_wy = in_data.pos_y;
  assign sm_we  = state == S_WRS;
  assign sm_wx  = ox;
  assign sm_wy  = oy;

  logic [AW-1:0] raw_waddr;
  assign raw_waddr = (in_data.eye ? AW'(WINDOW) : AW'(0)) + AW'(slot[in_data.eye]);

  gtms_ram #(.Width(CoordBits), .Depth(Depth)) u_raw_x (
    .clk, .we(raw_we), .waddr(raw_waddr), .wdata(raw_wx), .raddr, .rdata(rx));
  gtms_ram #(.Width(CoordBits), .Depth(Depth)) u_raw_y (
    .clk, .we(raw_we), .waddr(raw_waddr), .wdata(raw_wy), .raddr, .rdata(ry));
  gtms_ram #(.Width(CoordBits), .Depth(Depth)) u_sm_x (
    .clk, .we(sm_we), .waddr, .wdata(sm_wx), .raddr, .rdata(smx));
  gtms_ram #(.Width(CoordBits), .Depth(Depth)) u_sm_y (
    .clk, .we(sm_we), .waddr, .wdata(sm_wy), .raddr, .rdata(smy));

  // Rings are not cleared; valid flags make entries never written since reset read as zero.
  logic [Depth-1:0] raw_ok, sm_ok;
  logic             rok, sok;
  logic signed [CoordBits-1:0] vx, vy, wx, wy;
  assign vx = rok ? signed'(rx) : '0;
  assign vy = rok ? signed'(ry) : '0;
  assign wx = sok ? signed'(smx) : '0;
  assign wy = sok ? signed'(smy) : '0;

  // Deviation operand: WINDOW*p - S, for x (sub 0) or y (sub 1).
  logic signed [CoordBits-1:0] op_p;
  logic signed [SW-1:0]        op_s;
  logic                        smooth_sel;
  assign smooth_sel = state == S_SDEV;
  always_comb begin
    if (smooth_sel) begin
      op_p = sub[0] ? wy : wx;
      op_s = sub[0] ? sy : sx;
    end else begin
      op_p = sub[0] ? vy : vx;
      op_s = sub[0] ? sy : sx;
    end
  end
  assign mul_a = DW'(op_p) * DW'(WINDOW) - DW'(op_s);
  assign mul_w = (2*DW)'(mul_a);

  // Trimmed-mean division by a constant: the magnitude is multiplied by a
  // scaled reciprocal, which is exact over the whole range of the sum.
  logic signed [SW-1:0]        dsel;
  logic [SW-1:0]               dmag;
  logic [2*SW-1:0]             dprod;
  logic [CoordBits-1:0]        dq;
  logic signed [CoordBits-1:0] dres;
  assign dsel  = (state == S_DIVY) ? ty : tx;
  assign dmag  = dsel[SW-1] ? -dsel : dsel;
  assign dprod = {SW'(0), dmag} * {SW'(0), QMul};
  assign dq    = dprod[QShift +: CoordBits];
  assign dres  = dsel[SW-1] ? -dq : dq;

  logic [63:0] dev_cur;
  logic        first_dev;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      slot[0]   <= '0;
      slot[1]   <= '0;
      raw_ok    <= '0;
      sm_ok     <= '0;
      sq_start  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            eye <= in_data.eye;
            if (!bypass) begin
              raw_ok[raw_waddr] <= 1'b1;
            end
            idx <= '0; step <= '0; sub <= '0;
            sx <= '0; sy <= '0;
            state <= bypass ? S_WRS : S_SUM;
            ox <= in_data.pos_x;
            oy <= in_data.pos_y;
          end
        end
        S_SUM: begin
          // Read pipeline: address idx this cycle, data next cycle.
          rok  <= raw_ok[raddr];
          if (step != 0) begin
            sx <= sx + SW'(vx);
            sy <= sy + SW'(vy);
          end
          if (step == (IW+1)'(WINDOW)) begin
            state <= S_DEV; idx <= '0; step <= '0; sub <= '0;
            pass2 <= 1'b0; first_dev <= 1'b1;
          end else begin
            step <= step + 1'b1;
            if (idx != Last) idx <= idx + 1'b1;
          end
        end
        S_DEV: begin
          // Per entry: sub 0 read, 1 square y, 2 square x, 3 compare.
          unique case (sub)
            2'd0: begin rok <= raw_ok[raddr]; sub <= 2'd1; end
            2'd1: begin sq <= $unsigned(mul_w * mul_w); sub <= 2'd2; end
            2'd2: begin
              dev_cur <= 64'(sq);
              sq <= $unsigned(mul_w * mul_w); sub <= 2'd3;
            end
            default: begin
              sub <= 2'd0;
              if (!pass2) begin
                if (first_dev || dev_cur + 64'(sq) > dev_max1) begin
                  dev_max1 <= dev_cur + 64'(sq); d1 <= idx;
                end
              end else if (idx != d1 &&
                           (first_dev || dev_cur + 64'(sq) > dev_max2)) begin
                dev_max2 <= dev_cur + 64'(sq); d2 <= idx;
              end
              if (idx == Last) begin
                idx <= '0;
                first_dev <= 1'b1;
                if (pass2) begin
                  state <= S_TRIM; step <= '0; tx <= '0; ty <= '0;
                end
                pass2 <= 1'b1;
              end else begin
                idx <= idx + 1'b1;
                first_dev <= (pass2 && idx == d1 && first_dev);
              end
            end
          endcase
        end
        S_TRIM: begin
          rok  <= raw_ok[raddr];
          ridx <= idx;
          if (step != 0 && step != Tail && ridx != d1 && ridx != d2) begin
            tx <= tx + SW'(vx);
            ty <= ty + SW'(vy);
          end
          if (step == Tail) begin
            state <= S_DIVX;
          end else begin
            step <= step + 1'b1;
            if (idx != Last) idx <= idx + 1'b1;
          end
        end
        S_DIVX: begin
          ox <= dres;
          state <= S_DIVY;
        end
        S_DIVY: begin
          oy <= dres;
          state <= S_WRS;
        end
        S_WRS: begin
          sm_ok[waddr] <= 1'b1;
          slot[eye] <= (slot[eye] >= Last) ? '0 : slot[eye] + 1'b1;
          state <= S_SSUM; idx <= '0; step <= '0; sx <= '0; sy <= '0;
        end
        S_SSUM: begin
          sok <= sm_ok[raddr];
          if (step != 0) begin
            sx <= sx + SW'(wx);
            sy <= sy + SW'(wy);
          end
          if (step == (IW+1)'(WINDOW)) begin
            state <= S_SDEV; idx <= '0; sub <= '0; acc <= '0;
          end else begin
            step <= step + 1'b1;
            if (idx != Last) idx <= idx + 1'b1;
          end
        end
        S_SDEV: begin
          unique case (sub)
            2'd0: begin sok <= sm_ok[raddr]; sub <= 2'd1; end
            2'd1: begin sq <= $unsigned(mul_w * mul_w); sub <= 2'd2; end
            2'd2: begin
              acc <= acc + 64'(sq);
              sq <= $unsigned(mul_w * mul_w); sub <= 2'd3;
            end
            default: begin
              acc <= acc + 64'(sq);
              sub <= 2'd0;
              if (idx == Last) begin
                state <= S_SQRT; sq_start <= 1'b1;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          endcase
        end
        S_SQRT: begin
          sq_start <= 1'b0;
          if (sq_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.smooth_x <= ox;
            out_data.smooth_y <= oy;
            out_data.spread <= (root > 32'(2**SpreadBits - 1)) ?
                               SpreadBits'(2**SpreadBits - 1) : root[SpreadBits-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gtms_sqrt u_sqrt (
    .clk, .rst, .start(sq_start), .value(acc), .done(sq_done), .root);

  logic unused;
  assign unused = ^dprod ^ ^pwdata[31:1];
endmodule
`default_nettype wire

/* src/gtms_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smoother port checker
// Port-level properties of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module gtms_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire gtms_pkg::out_word_t out_data,
  input wire logic                pready
);
  a_busy_for_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall [*8]) else $error("not busy after a take");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result word dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("result word changed");
  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready) else $error("register port not ready");
endmodule

bind gaze_trimmed_mean_smoother_core gtms_checker u_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data, .pready);
`default_nettype wire

/* tb/sv/gaze_trimmed_mean_smoother_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaze trimmed-mean smoother testbench
// Drives gaze words for both eyes through the core in normal and bypass mode,
// predicts each trimmed mean and spread word and checks every output word.
// ----------------------------------------------------------------------------
module gaze_trimmed_mean_smoother_core_tb;
  import gtms_pkg::*;

  localparam int Win = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gaze_trimmed_mean_smoother_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  bit        hold_off = 1'b0;

  logic        bypass_mode = 1'b0;
  int          raw_x[2][Win], raw_y[2][Win], sm_x[2][Win], sm_y[2][Win];
  int          slot_of[2];

  function automatic longint sq_term(int p, longint s);
    longint d;
    d = Win * longint'(p) - s;
    return d * d;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, lo, hi, m;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      m = (lo + hi + 1) >> 1;
      if (m * m <= v) lo = m;
      else hi = m - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic out_word_t smooth_point(in_word_t w);
    out_word_t o;
    int e, s, i, d1, d2;
    longint sx, sy, tx, ty;
    longint unsigned dev[Win];
    longint unsigned acc, root;
    int ox, oy;
    e = w.eye;
    s = slot_of[e];
    ox = w.pos_x;
    oy = w.pos_y;
    if (!bypass_mode) begin
      raw_x[e][s] = w.pos_x;
      raw_y[e][s] = w.pos_y;
      sx = 0; sy = 0;
      for (i = 0; i < Win; i++) begin
        sx += raw_x[e][i];
        sy += raw_y[e][i];
      end
      for (i = 0; i < Win; i++)
        dev[i] = sq_term(raw_x[e][i], sx) + sq_term(raw_y[e][i], sy);
      d1 = 0;
      for (i = 1; i < Win; i++) if (dev[i] > dev[d1]) d1 = i;
      d2 = (d1 == 0) ? 1 : 0;
      for (i = 0; i < Win; i++) if (i != d1 && dev[i] > dev[d2]) d2 = i;
      tx = 0; ty = 0;
      for (i = 0; i < Win; i++) if (i != d1 && i != d2) begin
        tx += raw_x[e][i];
        ty += raw_y[e][i];
      end
      ox = int'(tx / (Win - 2));
      oy = int'(ty / (Win - 2));
    end
    sm_x[e][s] = ox;
    sm_y[e][s] = oy;
    slot_of[e] = (s + 1 >= Win) ? 0 : s + 1;
    sx = 0; sy = 0;
    for (i = 0; i < Win; i++) begin
      sx += sm_x[e][i];
      sy += sm_y[e][i];
    end
    acc = 0;
    for (i = 0; i < Win; i++)
      acc += sq_term(sm_x[e][i], sx) + sq_term(sm_y[e][i], sy);
    root = floor_root(acc);
    if (root > 64'd8388607) root = 64'd8388607;
    o.smooth_x = ox[15:0];
    o.smooth_y = oy[15:0];
    o.spread = root[22:0];
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 12)) begin
        in_data <= pending_words[0];
        expected_words.push_back(smooth_point(pending_words.pop_front()));
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_data);
        end else begin
          if (out_data !== expected_words[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x %0d y %0d spread %0d, got x %0d y %0d spread %0d",
                       expected_words[0].smooth_x, expected_words[0].smooth_y,
                       expected_words[0].spread, out_data.smooth_x, out_data.smooth_y,
                       out_data.spread);
          end
          void'(expected_words.pop_front());
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 12);
    end
  end

  task automatic write_bypass(logic v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 2'(RegBypass) << 2; pwdata <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    bypass_mode = v;
  endtask

  task automatic drain;
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic in_word_t rand_point(int spread_px);
    in_word_t w;
    int cx, cy;
    w.eye = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      w.pos_x = 16'($urandom);
      w.pos_y = 16'($urandom);
    end else begin
      cx = w.eye ? 300 : -200;
      cy = w.eye ? -150 : 400;
      w.pos_x = 16'(cx + int'($urandom_range(2 * spread_px)) - spread_px);
      w.pos_y = 16'(cy + int'($urandom_range(2 * spread_px)) - spread_px);
    end
    return w;
  endfunction

  task automatic queue_point(logic e, logic [15:0] x, logic [15:0] y);
    in_word_t w;
    w.eye = e; w.pos_x = x; w.pos_y = y;
    pending_words.push_back(w);
  endtask

  initial begin
    int n, i;
    for (i = 0; i < Win; i++) begin
      raw_x[0][i] = 0; raw_x[1][i] = 0; raw_y[0][i] = 0; raw_y[1][i] = 0;
      sm_x[0][i] = 0; sm_x[1][i] = 0; sm_y[0][i] = 0; sm_y[1][i] = 0;
    end
    slot_of[0] = 0; slot_of[1] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    queue_point(1'b0, 16'h0000, 16'h0000);
    queue_point(1'b0, 16'h7fff, 16'h8000);
    queue_point(1'b0, 16'h8000, 16'h7fff);
    queue_point(1'b1, 16'hffff, 16'h0001);
    queue_point(1'b1, 16'h7fff, 16'h7fff);
    queue_point(1'b1, 16'h8000, 16'h8000);
    for (i = 0; i < 6; i++) queue_point(1'b0, 16'h0005, 16'hfffb);
    drain();
    write_bypass(1'b1);
    queue_point(1'b0, 16'h7fff, 16'h8000);
    queue_point(1'b1, 16'h8000, 16'h7fff);
    queue_point(1'b0, 16'h1234, 16'hedcb);
    drain();
    write_bypass(1'b0);
    for (n = 0; n < 500; n++) pending_words.push_back(rand_point(n < 250 ? 20 : 3000));
    calm = 1'b1;
    while (pending_words.size() > 350) @(posedge clk);
    calm = 1'b0;
    hold_off = 1'b1;
    while (in_valid || expected_words.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    drain();
    write_bypass(1'b1);
    for (n = 0; n < 150; n++) pending_words.push_back(rand_point(500));
    drain();
    write_bypass(1'b0);
    for (n = 0; n < 450; n++) pending_words.push_back(rand_point(n < 300 ? 50 : 32767));
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
src/gtms_pkg.sv
src/gtms_ram.sv
src/gtms_sqrt.sv
src/gaze_trimmed_mean_smoother_core.sv
src/gtms_checker.sv
tb/sv/gaze_trimmed_mean_smoother_core_tb.sv
